// ----- rtl/prpm_pkg.sv -----
package prpm_pkg;

	localparam int OFFSET_WIDTH = 32;
	localparam int LENGTH_WIDTH = 16;
	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	localparam int CFG_ADDR_WIDTH = 3;
	localparam logic REG_MIN_RUN_LEN = 1'b0;
	localparam logic [7:0] MIN_RUN_LEN_RST = 8'd4;

	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_DEL = 16'h007F;
	localparam logic [15:0] CH_COLON = 16'h003A;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_DOT = 16'h002E;
	localparam logic [15:0] CH_STAR = 16'h002A;
	localparam logic [15:0] CH_QUEST = 16'h003F;
	localparam logic [15:0] CH_QUOTE = 16'h0022;
	localparam logic [15:0] CH_LT = 16'h003C;
	localparam logic [15:0] CH_GT = 16'h003E;
	localparam logic [15:0] CH_PIPE = 16'h007C;
	localparam logic [6:0] LOW_BSLASH = 7'h5C;
	localparam logic [6:0] LOW_DOT = 7'h2E;
	localparam int PATH_MIN_LEN = 6;

	typedef struct packed {
		logic [15:0] code_unit;
		logic last_unit;
	} unit_t;

	typedef struct packed {
		logic [OFFSET_WIDTH-1:0] run_start;
		logic [LENGTH_WIDTH-1:0] run_length;
		logic is_path;
	} result_t;

	// classified unit handed from front to back
	typedef struct packed {
		logic [OFFSET_WIDTH-1:0] offset;
		logic last;
		logic printable;
		logic upper;
		logic alnum;
		logic colon;
		logic bslash;
		logic dot;
		logic forbidden;
		logic [6:0] low7;
	} cls_item_t;

	typedef struct packed {
		logic prefix;
		logic bad;
		logic dot;
		logic dotbs;
		logic ext;
	} path_flags_t;

endpackage

// ----- rtl/prpm_fifo.sv -----
module prpm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/prpm_front.sv -----
module prpm_front
	import prpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  unit_t     unit,
	output logic      full,
	input  logic      q_full,
	output logic      q_push,
	output cls_item_t q_item
);

	logic [OFFSET_WIDTH-1:0] offset_q;
	logic [15:0] c;

	assign c = unit.code_unit;
	assign full = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		q_item.offset = offset_q;
		q_item.last = unit.last_unit;
		q_item.printable = (c >= CH_SPACE) && (c < CH_DEL);
		q_item.upper = (c >= 16'h0041) && (c <= 16'h005A);
		q_item.alnum = q_item.upper || ((c >= 16'h0061) && (c <= 16'h007A)) ||
			((c >= 16'h0030) && (c <= 16'h0039));
		q_item.colon = (c == CH_COLON);
		q_item.bslash = (c == CH_BSLASH);
		q_item.dot = (c == CH_DOT);
		q_item.forbidden = (c == CH_COLON) || (c == CH_STAR) || (c == CH_QUEST) ||
			(c == CH_QUOTE) || (c == CH_LT) || (c == CH_GT) || (c == CH_PIPE);
		q_item.low7 = c[6:0];
	end

	// offset restarts after the end of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (q_push) begin
			offset_q <= unit.last_unit ? '0 : offset_q + 1'b1;
		end
	end

endmodule

// ----- rtl/prpm_back.sv -----
module prpm_back
	import prpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] min_run_len,
	input  cls_item_t item,
	input  logic      item_empty,
	output logic      item_pop,
	input  logic      res_full,
	output logic      res_push,
	output result_t   res
);

	logic [OFFSET_WIDTH-1:0] start_q;
	logic [LENGTH_WIDTH-1:0] run_cnt_q;
	path_flags_t flags_q;
	logic [6:0] prev_q;

	logic [LENGTH_WIDTH-1:0] cnt_add;
	logic [OFFSET_WIDTH-1:0] start_add;
	path_flags_t f_add;
	logic close_run;
	logic [LENGTH_WIDTH-1:0] cl_cnt;
	logic [OFFSET_WIDTH-1:0] cl_start;
	path_flags_t cl_flags;
	logic [6:0] cl_last;
	logic [7:0] min_eff;

	assign item_pop = !item_empty && !res_full;

	// flag update for one printable unit
	always_comb begin
		f_add = (run_cnt_q == '0) ? '0 : flags_q;
		start_add = start_q;
		if (run_cnt_q == '0) begin
			start_add = item.offset;
			if (item.upper) begin
				f_add.prefix = 1'b1;
			end
		end else if (run_cnt_q == LENGTH_WIDTH'(1)) begin
			if (!item.colon) begin
				f_add.prefix = 1'b0;
			end
		end else if (run_cnt_q == LENGTH_WIDTH'(2)) begin
			if (!item.bslash) begin
				f_add.prefix = 1'b0;
			end
		end else begin
			if (item.bslash) begin
				if ((run_cnt_q >= LENGTH_WIDTH'(4)) && (prev_q == LOW_BSLASH)) begin
					f_add.bad = 1'b1;
				end
			end else if (item.forbidden) begin
				f_add.bad = 1'b1;
			end
		end
		if (item.dot) begin
			f_add.dot = 1'b1;
			f_add.ext = 1'b1;
			f_add.dotbs = (run_cnt_q != '0) && (prev_q == LOW_BSLASH);
		end else if (f_add.dot && !item.alnum) begin
			f_add.ext = 1'b0;
		end
		cnt_add = (run_cnt_q == '1) ? run_cnt_q : run_cnt_q + 1'b1;
	end

	// a run closes on a non-printable unit or after the last unit
	always_comb begin
		close_run = !item.printable || item.last;
		if (item.printable) begin
			cl_cnt = cnt_add;
			cl_start = start_add;
			cl_flags = f_add;
			cl_last = item.low7;
		end else begin
			cl_cnt = run_cnt_q;
			cl_start = start_q;
			cl_flags = flags_q;
			cl_last = prev_q;
		end
		min_eff = (min_run_len == '0) ? 8'd1 : min_run_len;
		res_push = item_pop && close_run && (cl_cnt >= LENGTH_WIDTH'(min_eff));
		res.run_start = cl_start;
		res.run_length = cl_cnt;
		res.is_path = cl_flags.prefix && !cl_flags.bad &&
			(cl_cnt >= LENGTH_WIDTH'(PATH_MIN_LEN)) && (cl_last != LOW_BSLASH) &&
			cl_flags.dot && (cl_last != LOW_DOT) && !cl_flags.dotbs && cl_flags.ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			run_cnt_q <= '0;
			flags_q <= '0;
			prev_q <= '0;
		end else if (item_pop) begin
			if (close_run) begin
				start_q <= '0;
				run_cnt_q <= '0;
				flags_q <= '0;
				prev_q <= '0;
			end else begin
				start_q <= start_add;
				run_cnt_q <= cnt_add;
				flags_q <= f_add;
				prev_q <= item.low7;
			end
		end
	end

`ifndef SYNTHESIS
	a_push_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> item_pop)
		else $error("result produced without consuming an item");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item.last) |=> (run_cnt_q == '0))
		else $error("run not cleared after last unit");
	a_nonprint_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && !item.printable) |=> (run_cnt_q == '0) && (flags_q == '0))
		else $error("run not cleared after non-printable unit");
	a_path_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.is_path) |-> (res.run_length >= LENGTH_WIDTH'(PATH_MIN_LEN)))
		else $error("path flag on short run");
`endif

endmodule

// ----- rtl/printable_run_path_matcher.sv -----
// Flow: an item is written into the classify queue, popped from it by the run tracker,
// and a result it closes is written into the result queue, whose head drives the result ports.
// Throughput: one code unit per cycle while neither queue is full; the run tracker updates once per unit.
// Queues between front, tracker and result port absorb stalls on either side.
// Reset (arst_n low, asynchronous): queues empty, run state and offset clear,
// min_run_len returns to 4.
module printable_run_path_matcher
	import prpm_pkg::*;
#(
	parameter int MID_DEPTH = MID_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  unit_t                     unit,
	output logic                      full,
	output result_t                   result,
	output logic                      empty,
	input  logic                      pop,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic [7:0] min_run_len_q;
	logic cfg_wr;

	logic mid_full;
	logic mid_push;
	cls_item_t mid_wr;
	cls_item_t mid_rd;
	logic mid_empty;
	logic mid_pop;

	logic res_full;
	logic res_push;
	result_t res_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MIN_RUN_LEN) ? {24'd0, min_run_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_len_q <= MIN_RUN_LEN_RST;
		end else if (cfg_wr && (paddr[2] == REG_MIN_RUN_LEN)) begin
			min_run_len_q <= pwdata[7:0];
		end
	end

	prpm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.unit   (unit),
		.full   (full),
		.q_full (mid_full),
		.q_push (mid_push),
		.q_item (mid_wr)
	);

	prpm_fifo #(
		.WIDTH ($bits(cls_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wr),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rd),
		.empty   (mid_empty)
	);

	prpm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.min_run_len (min_run_len_q),
		.item        (mid_rd),
		.item_empty  (mid_empty),
		.item_pop    (mid_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res_wr)
	);

	prpm_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

// ----- verif/tb_printable_run_path_matcher.sv -----
`timescale 1ns / 1ps

module tb_printable_run_path_matcher;
	import prpm_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [CFG_ADDR_WIDTH-1:0] MIN_LEN_ADDR = {REG_MIN_RUN_LEN, 2'b00};
	localparam logic [CFG_ADDR_WIDTH-1:0] UNMAPPED_ADDR = {1'b1, 2'b00};
	localparam logic [15:0] CH_UPPER_A = 16'h0041;
	localparam logic [15:0] CH_UPPER_Z = 16'h005A;
	localparam logic [15:0] CH_LOWER_A = 16'h0061;
	localparam logic [15:0] CH_LOWER_Z = 16'h007A;
	localparam logic [15:0] CH_DIGIT_0 = 16'h0030;
	localparam logic [15:0] CH_DIGIT_9 = 16'h0039;
	localparam logic [15:0] CH_UNDERSCORE = 16'h005F;
	localparam logic [15:0] CH_DASH = 16'h002D;
	localparam logic [15:0] CH_SEMI = 16'h003B;
	localparam logic [15:0] CH_SLASH = 16'h002F;
	localparam logic [15:0] CH_NUL = 16'h0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	unit_t unit = '0;
	logic full;
	result_t result;
	logic empty;
	logic pop = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	printable_run_path_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.unit(unit),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	unit_t pending_units[$];
	result_t expected_runs[$];
	int send_idle = 20;
	int recv_idle = 61;
	int errors = 0;
	int queued = 0;
	int quiet_cycles = 0;

	// scanner state mirrored from the block
	logic [7:0] run_min = MIN_RUN_LEN_RST;
	logic [OFFSET_WIDTH-1:0] next_offset = '0;
	logic [OFFSET_WIDTH-1:0] cur_start = '0;
	logic [LENGTH_WIDTH-1:0] cur_count = '0;
	path_flags_t cur_flags = '0;
	logic [13:0] tail_units = '0;

	function automatic bit is_alnum16(logic [15:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
			(c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
	endfunction

	function automatic bit is_forbidden16(logic [15:0] c);
		return c == CH_COLON || c == CH_STAR || c == CH_QUEST || c == CH_QUOTE ||
			c == CH_LT || c == CH_GT || c == CH_PIPE;
	endfunction

	task automatic close_run();
		logic [7:0] lim;
		logic [6:0] lastc;
		result_t r;
		lim = (run_min == 8'd0) ? 8'd1 : run_min;
		if (cur_count >= lim) begin
			lastc = tail_units[6:0];
			r.run_start = cur_start;
			r.run_length = cur_count;
			r.is_path = cur_flags.prefix && !cur_flags.bad && cur_count >= PATH_MIN_LEN &&
				lastc != LOW_BSLASH && cur_flags.dot && lastc != LOW_DOT &&
				!cur_flags.dotbs && cur_flags.ext;
			expected_runs.insert(expected_runs.size(), r);
		end
		cur_count = '0;
		cur_flags = '0;
		tail_units = '0;
		cur_start = '0;
	endtask

	task automatic extend_run(logic [15:0] c);
		logic [LENGTH_WIDTH-1:0] idx;
		logic [6:0] prev;
		path_flags_t f;
		idx = cur_count;
		prev = tail_units[6:0];
		f = (idx == 0) ? '0 : cur_flags;
		if (idx == 0) begin
			cur_start = next_offset;
			if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
				f.prefix = 1'b1;
		end else if (idx == 1) begin
			if (c != CH_COLON)
				f.prefix = 1'b0;
		end else if (idx == 2) begin
			if (c != CH_BSLASH)
				f.prefix = 1'b0;
		end else if (c == CH_BSLASH) begin
			// a doubled backslash right after the drive prefix is tolerated
			if (idx >= 4 && prev == LOW_BSLASH)
				f.bad = 1'b1;
		end else if (is_forbidden16(c)) begin
			f.bad = 1'b1;
		end
		if (c == CH_DOT) begin
			f.dot = 1'b1;
			f.ext = 1'b1;
			f.dotbs = (idx > 0 && prev == LOW_BSLASH);
		end else if (f.dot && !is_alnum16(c)) begin
			f.ext = 1'b0;
		end
		cur_flags = f;
		tail_units = {tail_units[6:0], c[6:0]};
		if (cur_count != '1)
			cur_count = cur_count + 1'b1;
	endtask

	task automatic scan_unit(unit_t u);
		if (u.code_unit >= CH_SPACE && u.code_unit < CH_DEL) begin
			extend_run(u.code_unit);
			if (u.last_unit)
				close_run();
		end else begin
			close_run();
		end
		next_offset = u.last_unit ? '0 : next_offset + 1'b1;
	endtask

	// driver: hold the item while full, else advance or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				scan_unit(unit);
			if (!push || !full) begin
				if (pending_units.size() != 0 && $urandom_range(99) >= send_idle) begin
					unit <= pending_units.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_runs.size() == 0) begin
					$display("%0t: unexpected result: got start %0d len %0d path %0b", $time,
						result.run_start, result.run_length, result.is_path);
					errors++;
				end else begin
					want = expected_runs.pop_front();
					if (result.run_start !== want.run_start || result.run_length !== want.run_length ||
						result.is_path !== want.is_path) begin
						$display("%0t: mismatch: expected start %0d len %0d path %0b, got start %0d len %0d path %0b",
							$time, want.run_start, want.run_length, want.is_path,
							result.run_start, result.run_length, result.is_path);
						errors++;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	task automatic put(logic [15:0] c, bit last);
		unit_t u;
		u.code_unit = c;
		u.last_unit = last;
		pending_units.insert(pending_units.size(), u);
		queued++;
	endtask

	task automatic put_text(string s, bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			put({8'h00, s[i]}, last_at_end && i == s.len() - 1);
	endtask

	function automatic logic [15:0] alnum_char();
		case ($urandom_range(2))
			0: return CH_UPPER_A + 16'($urandom_range(25));
			1: return CH_LOWER_A + 16'($urandom_range(25));
			default: return CH_DIGIT_0 + 16'($urandom_range(9));
		endcase
	endfunction

	function automatic logic [15:0] name_char();
		case ($urandom_range(9))
			6: return CH_SPACE;
			7: return CH_UNDERSCORE;
			8: return CH_DASH;
			9: return CH_DOT;
			default: return alnum_char();
		endcase
	endfunction

	function automatic logic [15:0] forbidden_char();
		case ($urandom_range(6))
			0: return CH_COLON;
			1: return CH_STAR;
			2: return CH_QUEST;
			3: return CH_QUOTE;
			4: return CH_LT;
			5: return CH_GT;
			default: return CH_PIPE;
		endcase
	endfunction

	function automatic logic [15:0] noise_code();
		case ($urandom_range(4))
			0: return 16'($urandom_range(31));
			1: return CH_DEL;
			2: return 16'($urandom_range(16'hFFFF, 16'h0080));
			default: return 16'($urandom);
		endcase
	endfunction

	// emit a run, then end it by a flagged last unit or a noise unit
	task automatic emit_run(logic [15:0] s[$]);
		bit by_last;
		by_last = ($urandom_range(3) == 0);
		foreach (s[i])
			put(s[i], by_last && i == s.size() - 1);
		if (!by_last)
			put(noise_code(), $urandom_range(7) == 0);
	endtask

	task automatic add_path(bit broken);
		logic [15:0] s[$];
		int dot_idx;
		int n;
		s.insert(s.size(), CH_UPPER_A + 16'($urandom_range(25)));
		s.insert(s.size(), CH_COLON);
		s.insert(s.size(), CH_BSLASH);
		if ($urandom_range(7) == 0)
			s.insert(s.size(), CH_BSLASH);
		repeat ($urandom_range(3)) begin
			repeat ($urandom_range(6, 1))
				s.insert(s.size(), name_char());
			s.insert(s.size(), CH_BSLASH);
		end
		repeat ($urandom_range(6, 1))
			s.insert(s.size(), name_char());
		dot_idx = s.size();
		s.insert(s.size(), CH_DOT);
		repeat ($urandom_range(4, 1))
			s.insert(s.size(), alnum_char());
		if (broken) begin
			case ($urandom_range(9))
				0: s[$urandom_range(s.size() - 1, 3)] = forbidden_char();
				1: begin
					n = $urandom_range(s.size() - 1, 4);
					s.insert(n, CH_BSLASH);
					s.insert(n, CH_BSLASH);
				end
				2: s.insert(s.size(), CH_BSLASH);
				3: s[0] = CH_LOWER_A + 16'($urandom_range(25));
				4: s[s.size() - 1] = CH_DASH;
				5: s.insert(dot_idx, CH_BSLASH);
				6: s.delete(dot_idx);
				7: s.insert(s.size(), CH_DOT);
				8: begin
					if ($urandom_range(1))
						s[1] = CH_SEMI;
					else
						s[2] = CH_SLASH;
				end
				default: begin
					while (s.size() > 5)
						s.delete(s.size() - 1);
				end
			endcase
		end
		emit_run(s);
	endtask

	task automatic add_text(int len);
		logic [15:0] s[$];
		repeat (len)
			s.insert(s.size(), 16'($urandom_range(16'h7E, 16'h20)));
		emit_run(s);
	endtask

	task automatic fill_random(int target);
		while (queued < target) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: add_path(1'b0);
				5, 6, 7: add_path(1'b1);
				8: repeat ($urandom_range(6, 1)) put(noise_code(), $urandom_range(9) == 0);
				default: add_text($urandom_range(12, 1));
			endcase
		end
	endtask

	// wait until all items are in and every result is out, then let the pipe drain
	task automatic settle();
		@(negedge clk);
		while (pending_units.size() != 0 || push || expected_runs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_ADDR_WIDTH-1:0] addr, logic [31:0] data);
		logic [31:0] want_rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == MIN_LEN_ADDR)
			run_min = data[7:0];
		@(negedge clk);
		want_rd = (addr == MIN_LEN_ADDR) ? {24'd0, run_min} : 32'd0;
		if (prdata !== want_rd) begin
			$display("%0t: register read mismatch: expected %0h, got %0h", $time,
				want_rd, prdata);
			errors++;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset minimum of four
		put_text("C:\\a.b", 1'b0);
		put(CH_NUL, 1'b0);
		put_text("ab", 1'b0);
		put(CH_DEL, 1'b0);
		put_text("C:\\\\x.y", 1'b0);
		put(16'h001F, 1'b0);
		put(CH_SPACE, 1'b0);
		put(16'h007E, 1'b0);
		put(16'h007E, 1'b0);
		put(CH_SPACE, 1'b1);
		put(16'hFFFF, 1'b1);
		settle();

		// zero minimum behaves as one; the unmapped write must not change it
		cfg_write(MIN_LEN_ADDR, {24'($urandom), 8'd0});
		cfg_write(UNMAPPED_ADDR, 32'($urandom_range(255, 200)));
		put(CH_UPPER_A, 1'b1);
		put(16'h007E, 1'b0);
		put(CH_NUL, 1'b0);
		settle();

		cfg_write(MIN_LEN_ADDR, {24'($urandom), 8'd255});
		add_text(255);
		add_text(254);
		settle();

		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin
					send_idle = 20;
					recv_idle = 61;
				end
				1: begin
					send_idle = 61;
					recv_idle = 20;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			cfg_write(MIN_LEN_ADDR,
				{24'($urandom), (m == 2) ? 8'd1 : 8'($urandom_range(6, 2))});
			if (m == 1)
				cfg_write(UNMAPPED_ADDR, $urandom);
			queued = 0;
			fill_random(100);
			if (m == 0)
				settle();
			fill_random(200);
			settle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
